// ===== hw/rtl/baro_pkg.sv =====
// ============================================================================
// baro_pkg
// Shared types, register indexes, reset values and word helpers for the
// barometric compensation pipeline.
// ============================================================================
package baro_pkg;

   // csr register indexes
   localparam logic [2:0] CSR_AC1_AC2 = 3'd0;
   localparam logic [2:0] CSR_AC3_AC4 = 3'd1;
   localparam logic [2:0] CSR_AC5_AC6 = 3'd2;
   localparam logic [2:0] CSR_B1_B2   = 3'd3;
   localparam logic [2:0] CSR_MC_MD   = 3'd4;

   // calibration reset values
   localparam logic [31:0] RST_AC1_AC2 = 32'd26804152;
   localparam logic [31:0] RST_AC3_AC4 = 32'd3352395749;
   localparam logic [31:0] RST_AC5_AC6 = 32'd2146785905;
   localparam logic [31:0] RST_B1_B2   = 32'd405667844;
   localparam logic [31:0] RST_MC_MD   = 32'd3724086068;

   // sample context that rides along the pipeline
   typedef struct packed {
      logic        err;
      logic [15:0] temp;
      logic [18:0] up;
   } side_type;

   // sign-extended upper and lower halves of a calibration word
   function automatic logic [31:0] hi_s(input logic [31:0] r);
      return {{16{r[31]}}, r[31:16]};
   endfunction

   function automatic logic [31:0] lo_s(input logic [31:0] r);
      return {{16{r[15]}}, r[15:0]};
   endfunction

   // low word of a 32 x 32 product
   function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] p;
      p = {32'd0, a} * {32'd0, b};
      return p[31:0];
   endfunction

   // signed divide by 2^k truncating toward zero
   function automatic logic [31:0] sdiv_p2(input logic [31:0] v, input logic [4:0] k);
      logic [31:0]        bias;
      logic signed [31:0] s;
      bias = v[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
      s    = $signed(v + bias);
      return $unsigned(s >>> k);
   endfunction

   // two's complement magnitude
   function automatic logic [31:0] abs32(input logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

endpackage

// ===== hw/rtl/baro_temp_pressure_compensation.sv =====
// ============================================================================
// baro_temp_pressure_compensation
// Barometric sensor temperature, pressure and altitude compensation pipeline.
// ============================================================================
// One request may be started in every clock cycle; busy never rises. Each
// result leaves 81 cycles after its request, strobed by rsp_valid for one
// cycle, and must be taken then. The latency is set by two 32-stage
// restoring dividers (one quotient bit per stage) for the X2 and pressure
// quotients, plus 17 arithmetic stages around them, one of which divides the
// altitude term by 11325 through a reciprocal multiply. Calibration words
// are written through the csr port while no request is in flight.
module baro_temp_pressure_compensation (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_raw_temp,
   input  logic [18:0] req_raw_press,
   output logic        rsp_valid,
   output logic signed [15:0] rsp_temperature,
   output logic [17:0] rsp_pressure,
   output logic signed [18:0] rsp_altitude,
   output logic        rsp_error,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import baro_pkg::*;

   // ceil(2^45 / 11325), exact quotient for any 32-bit dividend
   localparam logic [31:0] ALT_RECIP = 32'd3106787823;

   // calibration registers
   logic [31:0] cal0_ff, cal1_ff, cal2_ff, cal3_ff, cal4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal0_ff <= RST_AC1_AC2;
         cal1_ff <= RST_AC3_AC4;
         cal2_ff <= RST_AC5_AC6;
         cal3_ff <= RST_B1_B2;
         cal4_ff <= RST_MC_MD;
      end else if (csr_we) begin
         case (csr_index)
            CSR_AC1_AC2: cal0_ff <= csr_wdata;
            CSR_AC3_AC4: cal1_ff <= csr_wdata;
            CSR_AC5_AC6: cal2_ff <= csr_wdata;
            CSR_B1_B2:   cal3_ff <= csr_wdata;
            CSR_MC_MD:   cal4_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = hi_s(cal0_ff);
   assign ac2 = lo_s(cal0_ff);
   assign ac3 = hi_s(cal1_ff);
   assign ac4 = {16'd0, cal1_ff[15:0]};
   assign ac5 = {16'd0, cal2_ff[31:16]};
   assign ac6 = {16'd0, cal2_ff[15:0]};
   assign b1  = hi_s(cal3_ff);
   assign b2  = lo_s(cal3_ff);
   assign mc  = hi_s(cal4_ff);
   assign md  = lo_s(cal4_ff);

   assign busy = 1'b0;

   // valid bits of the arithmetic stages
   logic v1_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff, v10_ff;
   logic v11_ff, v12_ff, v13_ff, v14_ff, v15_ff, v16_ff, v17_ff, rsp_valid_ff;
   logic d1_valid, d2_valid;

   // stage 1: (UT - AC6) * AC5
   logic [31:0] prod1_ff;
   logic [18:0] up1_ff;
   always_ff @(posedge clock) begin
      prod1_ff <= mul32({16'd0, req_raw_temp} - ac6, ac5);
      up1_ff   <= req_raw_press;
   end

   // stage 2 feeds divider one: MC*2^11 / (X1 + MD)
   logic [31:0] x1t, dv1, mcs;
   logic [52:0] d1_tag_in, d1_tag;
   logic [31:0] d1_quot;
   always_comb begin
      x1t       = sdiv_p2(prod1_ff, 5'd15);
      dv1       = x1t + md;
      mcs       = mc << 11;
      d1_tag_in = {(dv1 == 32'd0), mcs[31] ^ dv1[31], x1t, up1_ff};
   end

   baro_div #(.W(32), .TW(53)) u_div_x2 (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v1_ff),
      .in_num   (abs32(mcs)),
      .in_den   (abs32(dv1)),
      .in_tag   (d1_tag_in),
      .out_valid(d1_valid),
      .out_quot (d1_quot),
      .out_tag  (d1_tag)
   );

   // stage 3: B5, temperature, B6
   logic [31:0] x2t, b5, tw;
   logic [15:0] t16;
   side_type    sd3_in;
   logic [31:0] b6_ff;
   side_type    sd3_ff;
   always_comb begin
      x2t = d1_tag[51] ? (~d1_quot + 32'd1) : d1_quot;
      b5  = d1_tag[50:19] + x2t;
      tw  = sdiv_p2(b5 + 32'd8, 5'd4);
      if ($signed(tw) > 32'sd32767) begin
         t16 = 16'h7FFF;
      end else if ($signed(tw) < -32'sd32768) begin
         t16 = 16'h8000;
      end else begin
         t16 = tw[15:0];
      end
      sd3_in.err  = d1_tag[52];
      sd3_in.temp = t16;
      sd3_in.up   = d1_tag[18:0];
   end
   always_ff @(posedge clock) begin
      b6_ff  <= b5 - 32'd4000;
      sd3_ff <= sd3_in;
   end

   // stage 4: B6 products
   logic [31:0] sq_ff, ac2b6_ff, ac3b6_ff;
   side_type    sd4_ff;
   always_ff @(posedge clock) begin
      sq_ff    <= mul32(b6_ff, b6_ff);
      ac2b6_ff <= mul32(ac2, b6_ff);
      ac3b6_ff <= mul32(ac3, b6_ff);
      sd4_ff   <= sd3_ff;
   end

   // stage 5: scale products
   logic [31:0] b6sq_ff, x2a_ff, x1c_ff;
   side_type    sd5_ff;
   always_ff @(posedge clock) begin
      b6sq_ff <= sdiv_p2(sq_ff, 5'd12);
      x2a_ff  <= sdiv_p2(ac2b6_ff, 5'd11);
      x1c_ff  <= sdiv_p2(ac3b6_ff, 5'd13);
      sd5_ff  <= sd4_ff;
   end

   // stage 6: B2 and B1 terms
   logic [31:0] b2p_ff, b1p_ff, x2a6_ff, x1c6_ff;
   side_type    sd6_ff;
   always_ff @(posedge clock) begin
      b2p_ff  <= mul32(b2, b6sq_ff);
      b1p_ff  <= mul32(b1, b6sq_ff);
      x2a6_ff <= x2a_ff;
      x1c6_ff <= x1c_ff;
      sd6_ff  <= sd5_ff;
   end

   // stage 7: X3 for B3 and for B4
   logic [31:0] x3a_ff, x3b_ff;
   side_type    sd7_ff;
   always_ff @(posedge clock) begin
      x3a_ff <= sdiv_p2(b2p_ff, 5'd11) + x2a6_ff;
      x3b_ff <= sdiv_p2(x1c6_ff + sdiv_p2(b1p_ff, 5'd16) + 32'd2, 5'd2);
      sd7_ff <= sd6_ff;
   end

   // stage 8: B3 and AC4 product
   logic [31:0] b3_ff, b4p_ff;
   side_type    sd8_ff;
   always_ff @(posedge clock) begin
      b3_ff  <= sdiv_p2((((ac1 << 2) + x3a_ff) << 3) + 32'd2, 5'd2);
      b4p_ff <= mul32(ac4, x3b_ff + 32'd32768);
      sd8_ff <= sd7_ff;
   end

   // stage 9: B4 with zero check, UP - B3
   logic [31:0] b4_ff, diff_ff;
   side_type    sd9_in, sd9_ff;
   always_comb begin
      sd9_in     = sd8_ff;
      sd9_in.err = sd8_ff.err | (b4p_ff[31:15] == 17'd0);
   end
   always_ff @(posedge clock) begin
      b4_ff   <= {15'd0, b4p_ff[31:15]};
      diff_ff <= {13'd0, sd8_ff.up} - b3_ff;
      sd9_ff  <= sd9_in;
   end

   // stage 10: B7
   logic [31:0] b7_ff, b4d_ff;
   side_type    sd10_ff;
   always_ff @(posedge clock) begin
      b7_ff   <= mul32(diff_ff, 32'd6250);
      b4d_ff  <= b4_ff;
      sd10_ff <= sd9_ff;
   end

   // divider two: p from B7 / B4
   logic [17:0] d2_tag_in, d2_tag;
   logic [31:0] d2_quot;
   assign d2_tag_in = {sd10_ff.err, b7_ff[31], sd10_ff.temp};

   baro_div #(.W(32), .TW(18)) u_div_p (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v10_ff),
      .in_num   (b7_ff[31] ? b7_ff : {b7_ff[30:0], 1'b0}),
      .in_den   (b4d_ff),
      .in_tag   (d2_tag_in),
      .out_valid(d2_valid),
      .out_quot (d2_quot),
      .out_tag  (d2_tag)
   );

   // stage 11: p, p/2^8 and -7357*p
   logic [31:0] pw;
   logic [31:0] p11_ff, pd_ff, x2p_ff;
   logic [16:0] tg11_ff;
   assign pw = d2_tag[16] ? {d2_quot[30:0], 1'b0} : d2_quot;
   always_ff @(posedge clock) begin
      p11_ff  <= pw;
      pd_ff   <= sdiv_p2(pw, 5'd8);
      x2p_ff  <= mul32(32'hFFFF_E343, pw);
      tg11_ff <= {d2_tag[17], d2_tag[15:0]};
   end

   // stage 12: square and X2
   logic [31:0] p12_ff, x1p_ff, x2q_ff;
   logic [16:0] tg12_ff;
   always_ff @(posedge clock) begin
      p12_ff  <= p11_ff;
      x1p_ff  <= mul32(pd_ff, pd_ff);
      x2q_ff  <= sdiv_p2(x2p_ff, 5'd16);
      tg12_ff <= tg11_ff;
   end

   // stage 13: X1 * 3038
   logic [31:0] p13_ff, x1q_ff, x2q13_ff;
   logic [16:0] tg13_ff;
   always_ff @(posedge clock) begin
      p13_ff   <= p12_ff;
      x1q_ff   <= mul32(x1p_ff, 32'd3038);
      x2q13_ff <= x2q_ff;
      tg13_ff  <= tg12_ff;
   end

   // stage 14: correction sum
   logic [31:0] p14_ff, sum_ff;
   logic [16:0] tg14_ff;
   always_ff @(posedge clock) begin
      p14_ff  <= p13_ff;
      sum_ff  <= sdiv_p2(x1q_ff, 5'd16) + x2q13_ff + 32'd3791;
      tg14_ff <= tg13_ff;
   end

   // stage 15: final pressure word
   logic [31:0] pr_ff;
   logic [16:0] tg15_ff;
   always_ff @(posedge clock) begin
      pr_ff   <= p14_ff + sdiv_p2(sum_ff, 5'd4);
      tg15_ff <= tg14_ff;
   end

   // stage 16: altitude product and pressure saturation
   logic [17:0] psat;
   logic [31:0] ap_ff;
   logic [17:0] ps16_ff;
   logic [16:0] tg16_ff;
   always_comb begin
      if (pr_ff[31]) begin
         psat = 18'd0;
      end else if (pr_ff > 32'd262143) begin
         psat = 18'h3FFFF;
      end else begin
         psat = pr_ff[17:0];
      end
   end
   always_ff @(posedge clock) begin
      ap_ff   <= mul32(pr_ff - 32'd90000, 32'd9890);
      ps16_ff <= psat;
      tg16_ff <= tg15_ff;
   end

   // stage 17: altitude magnitude times the reciprocal of 11325
   logic [63:0] aprod_ff;
   logic        an17_ff;
   logic [17:0] ps17_ff;
   logic [16:0] tg17_ff;
   always_ff @(posedge clock) begin
      aprod_ff <= {32'd0, abs32(ap_ff)} * {32'd0, ALT_RECIP};
      an17_ff  <= ap_ff[31];
      ps17_ff  <= ps16_ff;
      tg17_ff  <= tg16_ff;
   end

   // output stage: altitude, saturation, error zeroing
   logic [31:0] aq, alt;
   logic [18:0] asat;
   logic signed [15:0] temp_ff;
   logic [17:0] press_ff;
   logic signed [18:0] alt_ff;
   logic error_ff;
   always_comb begin
      aq  = an17_ff ? (~{13'd0, aprod_ff[63:45]} + 32'd1) : {13'd0, aprod_ff[63:45]};
      alt = 32'd9890 - aq;
      if ($signed(alt) > 32'sd262143) begin
         asat = 19'h3FFFF;
      end else if ($signed(alt) < -32'sd262144) begin
         asat = 19'h40000;
      end else begin
         asat = alt[18:0];
      end
   end
   always_ff @(posedge clock) begin
      error_ff <= tg17_ff[16];
      temp_ff  <= tg17_ff[16] ? 16'sd0 : $signed(tg17_ff[15:0]);
      press_ff <= tg17_ff[16] ? 18'd0 : ps17_ff;
      alt_ff   <= tg17_ff[16] ? 19'sd0 : $signed(asat);
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         v8_ff        <= 1'b0;
         v9_ff        <= 1'b0;
         v10_ff       <= 1'b0;
         v11_ff       <= 1'b0;
         v12_ff       <= 1'b0;
         v13_ff       <= 1'b0;
         v14_ff       <= 1'b0;
         v15_ff       <= 1'b0;
         v16_ff       <= 1'b0;
         v17_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= start & ~busy;
         v3_ff        <= d1_valid;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         v7_ff        <= v6_ff;
         v8_ff        <= v7_ff;
         v9_ff        <= v8_ff;
         v10_ff       <= v9_ff;
         v11_ff       <= d2_valid;
         v12_ff       <= v11_ff;
         v13_ff       <= v12_ff;
         v14_ff       <= v13_ff;
         v15_ff       <= v14_ff;
         v16_ff       <= v15_ff;
         v17_ff       <= v16_ff;
         rsp_valid_ff <= v17_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_temperature = temp_ff;
   assign rsp_pressure    = press_ff;
   assign rsp_altitude    = alt_ff;
   assign rsp_error       = error_ff;

`ifndef ASSERT_OFF
   a_error_zeroes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error) |->
         (rsp_temperature == 16'sd0 && rsp_pressure == 18'd0 && rsp_altitude == 19'sd0))
      else $error("error result with nonzero fields");
   a_rsp_from_alt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(v17_ff))
      else $error("result without altitude stage");
   a_b4_zero_flag: assert property (@(posedge clock) disable iff (reset)
      (v9_ff && b4_ff == 32'd0) |-> sd9_ff.err)
      else $error("zero B4 not flagged");
`endif

endmodule

// ===== hw/rtl/baro_div.sv =====
// ============================================================================
// baro_div
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// tag that travels alongside each request.
// ============================================================================
module baro_div #(
   parameter int W  = 32,
   parameter int TW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [W-1:0]  in_num,
   input  logic [W-1:0]  in_den,
   input  logic [TW-1:0] in_tag,
   output logic          out_valid,
   output logic [W-1:0]  out_quot,
   output logic [TW-1:0] out_tag
);

   logic [W-1:0]  rem_ff [W];
   logic [W-1:0]  num_ff [W];
   logic [W-1:0]  den_ff [W];
   logic [W-1:0]  quo_ff [W];
   logic [TW-1:0] tag_ff [W];
   logic [W-1:0]  vld_ff;

   logic [W-1:0]  rem_i [W];
   logic [W-1:0]  num_i [W];
   logic [W-1:0]  den_i [W];
   logic [W-1:0]  quo_i [W];
   logic [TW-1:0] tag_i [W];
   logic [W-1:0]  vld_i;

   logic [W-1:0]  rem_in [W];
   logic [W-1:0]  quo_in [W];

   for (genvar k = 0; k < W; k++) begin : g_stage
      // stage input select
      if (k == 0) begin : g_first
         assign rem_i[k] = '0;
         assign num_i[k] = in_num;
         assign den_i[k] = in_den;
         assign quo_i[k] = '0;
         assign tag_i[k] = in_tag;
         assign vld_i[k] = in_valid;
      end else begin : g_next
         assign rem_i[k] = rem_ff[k-1];
         assign num_i[k] = num_ff[k-1];
         assign den_i[k] = den_ff[k-1];
         assign quo_i[k] = quo_ff[k-1];
         assign tag_i[k] = tag_ff[k-1];
         assign vld_i[k] = vld_ff[k-1];
      end

      // one compare and subtract
      logic [W:0] sh;
      logic       ge;
      always_comb begin
         sh        = {rem_i[k], num_i[k][W-1]};
         ge        = (sh >= {1'b0, den_i[k]});
         rem_in[k] = ge ? sh[W-1:0] - den_i[k] : sh[W-1:0];
         quo_in[k] = {quo_i[k][W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_i[k];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in[k];
         num_ff[k] <= {num_i[k][W-2:0], 1'b0};
         den_ff[k] <= den_i[k];
         quo_ff[k] <= quo_in[k];
         tag_ff[k] <= tag_i[k];
      end
   end

   assign out_valid = vld_ff[W-1];
   assign out_quot  = quo_ff[W-1];
   assign out_tag   = tag_ff[W-1];

`ifndef ASSERT_OFF
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[W-1] && den_ff[W-1] != '0) |-> (rem_ff[W-1] < den_ff[W-1]))
      else $error("divider remainder not below divisor");
   a_zero_den_ones: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[W-1] && den_ff[W-1] == '0) |-> (quo_ff[W-1] == '1))
      else $error("divide by zero quotient not all ones");
   a_valid_travels: assert property (@(posedge clock) disable iff (reset)
      vld_ff[W-1] |-> $past(vld_ff[W-2]))
      else $error("divider valid skipped a stage");
`endif

endmodule
